### rtl/core/population_std_deviation_unit_assert.svh
// assertion macros for the population standard deviation unit checkers
`ifndef POPULATION_STD_DEVIATION_UNIT_ASSERT_SVH
`define POPULATION_STD_DEVIATION_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, disabled while reset is asserted
`define PSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### rtl/core/psd_pkg.sv
// shared constants and types for the population standard deviation unit
package psd_pkg;

    // default sizing
    localparam int PSD_MAX_SAMPLES = 1024;
    localparam int PSD_SAMPLE_BITS = 16;

    // fixed widths of the result fields
    localparam int PSD_STD_W   = 16;
    localparam int PSD_MEAN_W  = 16;
    localparam int PSD_COUNT_W = 11;

    // status of a multi-cycle arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } psd_stat_t;

endpackage

### rtl/core/psd_divider.sv
// restoring unsigned divider, one quotient bit per cycle
module psd_divider
    import psd_pkg::*;
#(
    parameter int DVD_W = 43,
    parameter int DVS_W = 11
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output psd_stat_t        stat,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DVS_W:0]    rem_shift;
    logic [DVS_W:0]    rem_diff;
    logic              fits;
    logic [DVS_W-1:0]  rem_next;

    // one trial subtraction per cycle
    always_comb begin
        rem_shift = {rem_reg, quo_reg[DVD_W-1]};
        rem_diff  = rem_shift - {1'b0, divisor};
        fits      = (rem_shift >= {1'b0, divisor});
        rem_next  = fits ? rem_diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DVD_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

### rtl/core/psd_sqrt.sv
// digit-by-digit floor square root, one result bit per cycle
module psd_sqrt
    import psd_pkg::*;
#(
    parameter int W = 43
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] radicand,
    output psd_stat_t    stat,
    output logic [W-1:0] root
);

    // highest power of four that fits in W bits
    localparam int BIT0 = 2 * ((W - 1) / 2);

    logic [W-1:0] x_reg;
    logic [W-1:0] res_reg;
    logic [W-1:0] bit_reg;
    logic         busy_reg;
    logic         done_reg;

    logic [W:0]   trial;
    logic         ge;

    // compare remainder against res + bit
    always_comb begin
        trial = {1'b0, res_reg} + {1'b0, bit_reg};
        ge    = ({1'b0, x_reg} >= trial);
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg[0]) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= W'(1) << BIT0;
        end else if (busy_reg) begin
            if (ge) begin
                x_reg   <= x_reg - trial[W-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = res_reg;

endmodule

### rtl/core/population_std_deviation_unit.sv
// Population standard deviation unit: while loading, samples stream in one per cycle and are
// kept in an on-chip sample memory of MAX_SAMPLES entries (extra samples are dropped and flagged).
// A request with s_last set closes the set; the unit then stops taking requests and runs
// two passes: the mean through a bit-serial divider with an SQ_W-bit dividend (SQ_W =
// 2*SAMPLE_BITS + clog2(MAX_SAMPLES+1), 43 by default), then one memory read per stored
// sample through a subtract/square/accumulate pipeline, then the variance through the
// same divider and a bit-serial square root. The result sits in an output register, so
// loading of the next set starts while the previous result waits for m_ready.
module population_std_deviation_unit
    import psd_pkg::*;
#(
    parameter int MAX_SAMPLES = PSD_MAX_SAMPLES,
    parameter int SAMPLE_BITS = PSD_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [PSD_STD_W-1:0]          m_std_dev,
    output logic signed [PSD_MEAN_W-1:0]  m_mean,
    output logic [PSD_COUNT_W-1:0]        m_count,
    output logic                          m_overflowed
);

    localparam int SB     = SAMPLE_BITS;
    localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = SB + CNT_W;
    localparam int SQ_W   = 2 * SB + CNT_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

    // sequencer codes
    localparam logic [3:0] ST_LOAD    = 4'd0;
    localparam logic [3:0] ST_M_START = 4'd1;
    localparam logic [3:0] ST_M_WAIT  = 4'd2;
    localparam logic [3:0] ST_PASS    = 4'd3;
    localparam logic [3:0] ST_V_START = 4'd4;
    localparam logic [3:0] ST_V_WAIT  = 4'd5;
    localparam logic [3:0] ST_R_START = 4'd6;
    localparam logic [3:0] ST_R_WAIT  = 4'd7;
    localparam logic [3:0] ST_DONE    = 4'd8;

    logic [3:0]             state_reg;
    logic [3:0]             state_next;

    logic [CNT_W-1:0]       count_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                   dropped_reg;
    logic signed [SB-1:0]   mean_reg;

    // second pass pipeline
    logic [CNT_W-1:0]       idx_reg;
    logic                   rd_v_reg;
    logic                   d_v_reg;
    logic                   s_v_reg;
    logic [SB-1:0]          rdata_reg;
    logic [SB-1:0]          dabs_reg;
    logic [2*SB-1:0]        sq_reg;
    logic [SQ_W-1:0]        acc_reg;

    // result register
    logic                   m_valid_reg;
    logic [PSD_STD_W-1:0]   std_reg;
    logic [PSD_MEAN_W-1:0]  mean_out_reg;
    logic [PSD_COUNT_W-1:0] count_out_reg;
    logic                   ovf_out_reg;

    logic [SB-1:0]          mem [MAX_SAMPLES];

    logic                   accept;
    logic                   wr_en;
    logic                   rd_en;
    logic                   pass_end;
    logic                   out_load;
    logic [SUM_W-1:0]       sum_abs;
    logic [SQ_W-1:0]        div_dividend;
    logic                   div_start;
    psd_stat_t              div_stat;
    logic [SQ_W-1:0]        div_quo;
    psd_stat_t              sqrt_stat;
    logic [SQ_W-1:0]        sqrt_root;
    logic [SB-1:0]          mean_mag;
    logic signed [SB:0]     diff;
    logic [SB:0]            diff_abs;
    logic [SQ_W-1:0]        mean_ext;
    logic [SQ_W-1:0]        count_ext;

    // handshakes and strobes
    always_comb begin
        accept    = s_valid && s_ready;
        wr_en     = accept && (count_reg < MAX_CNT);
        rd_en     = (state_reg == ST_PASS) && (idx_reg != count_reg);
        pass_end  = (state_reg == ST_PASS) && (idx_reg == count_reg)
                    && !rd_v_reg && !d_v_reg && !s_v_reg;
        out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
        div_start = (state_reg == ST_M_START) || (state_reg == ST_V_START);
    end

    assign s_ready = (state_reg == ST_LOAD);

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:    if (accept && s_last) state_next = ST_M_START;
            ST_M_START: state_next = ST_M_WAIT;
            ST_M_WAIT:  if (div_stat.done) state_next = ST_PASS;
            ST_PASS:    if (pass_end) state_next = ST_V_START;
            ST_V_START: state_next = ST_V_WAIT;
            ST_V_WAIT:  if (div_stat.done) state_next = ST_R_START;
            ST_R_START: state_next = ST_R_WAIT;
            ST_R_WAIT:  if (sqrt_stat.done) state_next = ST_DONE;
            ST_DONE:    if (out_load) state_next = ST_LOAD;
            default:    state_next = ST_LOAD;
        endcase
    end

    // divider operand: magnitude of the sum, then the squared-deviation total
    always_comb begin
        sum_abs      = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        div_dividend = (state_reg == ST_M_START) ? {{(SQ_W-SUM_W){1'b0}}, sum_abs} : acc_reg;
        mean_mag     = div_quo[SB-1:0];
    end

    // sample memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[ADDR_W-1:0]] <= s_sample;
        end
        if (rd_en) begin
            rdata_reg <= mem[idx_reg[ADDR_W-1:0]];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            sum_reg     <= '0;
            dropped_reg <= 1'b0;
            idx_reg     <= '0;
            rd_v_reg    <= 1'b0;
            d_v_reg     <= 1'b0;
            s_v_reg     <= 1'b0;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rd_v_reg  <= rd_en;
            d_v_reg   <= rd_v_reg;
            s_v_reg   <= d_v_reg;

            // set loading
            if (wr_en) begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_reg + {{(SUM_W-SB){s_sample[SB-1]}}, s_sample};
            end else if (accept) begin
                dropped_reg <= 1'b1;
            end

            // second pass bookkeeping
            if (state_reg == ST_M_START) begin
                idx_reg <= '0;
                acc_reg <= '0;
            end else begin
                if (rd_en) idx_reg <= idx_reg + 1'b1;
                if (s_v_reg) acc_reg <= acc_reg + {{(SQ_W-2*SB){1'b0}}, sq_reg};
            end

            // result hand-off and clear for the next set
            if (out_load) begin
                m_valid_reg <= 1'b1;
                count_reg   <= '0;
                sum_reg     <= '0;
                dropped_reg <= 1'b0;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // truncated mean with sign restored
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_M_WAIT) && div_stat.done) begin
            mean_reg <= sum_reg[SUM_W-1] ? -mean_mag : mean_mag;
        end
    end

    // deviation and square
    always_comb begin
        diff     = {rdata_reg[SB-1], rdata_reg} - {mean_reg[SB-1], mean_reg};
        diff_abs = diff[SB] ? (SB+1)'(-diff) : (SB+1)'(diff);
    end

    always_ff @(posedge aclk) begin
        if (rd_v_reg) dabs_reg <= diff_abs[SB-1:0];
        if (d_v_reg)  sq_reg   <= dabs_reg * dabs_reg;
    end

    // output fields at their fixed widths
    always_comb begin
        mean_ext  = {{(SQ_W-SB){mean_reg[SB-1]}}, mean_reg};
        count_ext = {{(SQ_W-CNT_W){1'b0}}, count_reg};
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            std_reg       <= sqrt_root[PSD_STD_W-1:0];
            mean_out_reg  <= mean_ext[PSD_MEAN_W-1:0];
            count_out_reg <= count_ext[PSD_COUNT_W-1:0];
            ovf_out_reg   <= dropped_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_std_dev    = std_reg;
    assign m_mean       = mean_out_reg;
    assign m_count      = count_out_reg;
    assign m_overflowed = ovf_out_reg;

    // shared divider for mean and variance
    psd_divider #(
        .DVD_W (SQ_W),
        .DVS_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // square root of the variance
    psd_sqrt #(
        .W (SQ_W)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_R_START),
        .radicand (div_quo),
        .stat     (sqrt_stat),
        .root     (sqrt_root)
    );

endmodule

### rtl/core/psd_checker.sv
// port-level checker for the population standard deviation unit, with its bind
`include "population_std_deviation_unit_assert.svh"

module psd_checker
    import psd_pkg::*;
#(
    parameter int MAX_SAMPLES = PSD_MAX_SAMPLES,
    parameter int SAMPLE_BITS = PSD_SAMPLE_BITS
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic signed [SAMPLE_BITS-1:0] s_sample,
    input logic                          s_last,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [PSD_STD_W-1:0]          m_std_dev,
    input logic signed [PSD_MEAN_W-1:0]  m_mean,
    input logic [PSD_COUNT_W-1:0]        m_count,
    input logic                          m_overflowed
);

    logic [SAMPLE_BITS:0]                                req_bits;
    logic [PSD_STD_W+PSD_MEAN_W+PSD_COUNT_W:0]          out_bits;

    // request and result payloads as single vectors
    assign req_bits = {s_sample, s_last};
    assign out_bits = {m_std_dev, m_mean, m_count, m_overflowed};

    // a waiting request stays offered with its fields
    `PSD_ASSERT_NXT(a_req_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(req_bits))

    // a stalled result stays offered
    `PSD_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)

    // a stalled result keeps its fields
    `PSD_ASSERT_NXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(out_bits))

    // closing a set starts computation, so no request is taken next cycle
    `PSD_ASSERT_NXT(a_last_busy, aclk, aresetn, s_valid && s_ready && s_last, !s_ready)

    // a set with dropped samples used the full store
    `PSD_ASSERT_NOW(a_ovf_count, aclk, aresetn, m_valid && m_overflowed, m_count == PSD_COUNT_W'(MAX_SAMPLES))

endmodule

bind population_std_deviation_unit psd_checker #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_psd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_sample     (s_sample),
    .s_last       (s_last),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_std_dev    (m_std_dev),
    .m_mean       (m_mean),
    .m_count      (m_count),
    .m_overflowed (m_overflowed)
);

### tb/population_std_deviation_unit_test.sv
// self-checking testbench for the population standard deviation unit
`timescale 1ns / 100ps

module population_std_deviation_unit_test;
    import psd_pkg::*;

    localparam int RUN_LIMIT  = 1_000_000;
    localparam int DRAIN_WAIT = 200;
    localparam int RAND_ITEMS = 2000;
    localparam int RAND_SETS  = 40;

    typedef logic signed [PSD_SAMPLE_BITS-1:0] sample_t;

    // one request on the sample channel
    typedef struct {
        sample_t sample;
        logic    is_last;
    } sample_req_t;

    // one set summary on the result channel
    typedef struct {
        logic [PSD_STD_W-1:0]          std_dev;
        logic signed [PSD_MEAN_W-1:0]  mean;
        logic [PSD_COUNT_W-1:0]        count;
        logic                          overflowed;
    } set_stats_t;

    // how the samples of one set are spread
    typedef enum int {
        SPREAD_FULL,
        SPREAD_EXTREME,
        SPREAD_NARROW,
        SPREAD_TINY
    } spread_t;

    // result-side stall behavior
    typedef enum int {
        READY_ALWAYS,
        READY_DENSE,
        READY_SPARSE,
        READY_BLOCKED
    } ready_mode_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    sample_t                       s_sample;
    logic                          s_last;
    logic                          m_valid;
    logic                          m_ready;
    logic [PSD_STD_W-1:0]          m_std_dev;
    logic signed [PSD_MEAN_W-1:0]  m_mean;
    logic [PSD_COUNT_W-1:0]        m_count;
    logic                          m_overflowed;

    population_std_deviation_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_std_dev    (m_std_dev),
        .m_mean       (m_mean),
        .m_count      (m_count),
        .m_overflowed (m_overflowed)
    );

    sample_req_t pending_requests[$];
    set_stats_t  expected_stats[$];

    // running state of the set being collected
    longint      stored_samples[$];
    longint      sample_total;
    logic        samples_dropped;

    int          total_requests;
    int          requests_taken;
    int          sets_queued;
    int          sets_checked;
    int          sets_with_drops;
    int          largest_count;
    int          mismatches;
    int          cycle_count;
    logic        req_taken;

    int          burst_left;
    int          gap_left;
    ready_mode_t ready_mode;
    int          mode_left;
    int          hold_left;

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // floor square root, one result bit at a time from the top
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        int              b;
        root = 0;
        for (b = 16; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // fold one accepted request into the set; close it on the last one
    task automatic absorb_sample(input sample_t sample, input logic is_last);
        set_stats_t      stats;
        longint          mean;
        longint          dev;
        longint unsigned dev_sq_sum;
        int              n;
        if (stored_samples.size() < PSD_MAX_SAMPLES) begin
            stored_samples.push_back(longint'(sample));
            sample_total += longint'(sample);
        end else begin
            samples_dropped = 1'b1;
        end
        if (is_last) begin
            n = stored_samples.size();
            // truncating division rounds toward zero
            mean = sample_total / longint'(n);
            dev_sq_sum = 0;
            foreach (stored_samples[i]) begin
                dev = stored_samples[i] - mean;
                dev_sq_sum += longint'(dev * dev);
            end
            stats.std_dev    = PSD_STD_W'(floor_root(dev_sq_sum / longint'(n)));
            stats.mean       = PSD_MEAN_W'(mean);
            stats.count      = PSD_COUNT_W'(n);
            stats.overflowed = samples_dropped;
            expected_stats.push_back(stats);
            if (samples_dropped) begin
                sets_with_drops++;
            end
            if (n > largest_count) begin
                largest_count = n;
            end
            stored_samples.delete();
            sample_total = 0;
            samples_dropped = 1'b0;
        end
    endtask

    // queue a set with the given values, last flag on the final one
    task automatic queue_set(input int vals[$]);
        sample_req_t req;
        foreach (vals[i]) begin
            req.sample  = sample_t'(vals[i]);
            req.is_last = (i == vals.size() - 1);
            pending_requests.push_back(req);
        end
        sets_queued++;
    endtask

    // queue a set of random samples drawn with one spread
    task automatic queue_random_set(input int size, input spread_t spread);
        int vals[$];
        int center;
        int v;
        center = int'($urandom_range(0, 65535)) - 32768;
        repeat (size) begin
            case (spread)
                SPREAD_FULL: begin
                    v = int'(sample_t'($urandom));
                end
                SPREAD_EXTREME: begin
                    v = $urandom_range(0, 1) ? 32767 : -32768;
                end
                SPREAD_NARROW: begin
                    v = center + int'($urandom_range(0, 200)) - 100;
                    if (v > 32767) v = 32767;
                    if (v < -32768) v = -32768;
                end
                default: begin
                    v = int'($urandom_range(0, 16)) - 8;
                end
            endcase
            vals.push_back(v);
        end
        queue_set(vals);
    endtask

    // request driver: bursts with random gaps, holds until accepted
    always @(negedge aclk) begin : drive_requests
        logic        nv;
        sample_req_t nr;
        nv         = s_valid;
        nr.sample  = s_sample;
        nr.is_last = s_last;
        if (aresetn && (!s_valid || req_taken)) begin
            if (gap_left > 0) begin
                nv = 1'b0;
                gap_left--;
            end else if (pending_requests.size() > 0) begin
                nr = pending_requests.pop_front();
                nv = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                nv = 1'b0;
            end
        end
        s_valid  <= nv;
        s_sample <= nr.sample;
        s_last   <= nr.is_last;
    end

    // result-side ready pattern, switching to a random mode whenever the current one runs out
    always @(negedge aclk) begin : drive_ready
        logic r;
        if (mode_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 400);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            READY_ALWAYS: r = 1'b1;
            READY_DENSE:  r = ($urandom_range(0, 3) != 0);
            READY_SPARSE: r = ($urandom_range(0, 3) == 0);
            default: begin
                if (hold_left > 0) begin
                    r = 1'b0;
                    hold_left--;
                end else begin
                    r = 1'b1;
                    hold_left = $urandom_range(0, 1) ? $urandom_range(1, 40) : 0;
                end
            end
        endcase
        m_ready <= r;
    end

    // accepted requests feed the predictor
    always @(posedge aclk) begin : watch_requests
        req_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            absorb_sample(s_sample, s_last);
            requests_taken++;
        end
    end

    // accepted results are checked against the oldest prediction
    always @(posedge aclk) begin : watch_results
        set_stats_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_stats.size() == 0) begin
                $display("[%0t] unexpected result: std_dev=%0d mean=%0d count=%0d overflowed=%0d",
                         $time, m_std_dev, m_mean, m_count, m_overflowed);
                mismatches++;
            end else begin
                want = expected_stats.pop_front();
                if (m_std_dev !== want.std_dev || m_mean !== want.mean ||
                    m_count !== want.count || m_overflowed !== want.overflowed) begin
                    $display("[%0t] set %0d mismatch: expected std_dev=%0d mean=%0d count=%0d ovf=%0d",
                             $time, sets_checked, want.std_dev, want.mean, want.count,
                             want.overflowed);
                    $display("[%0t] set %0d mismatch: actual   std_dev=%0d mean=%0d count=%0d ovf=%0d",
                             $time, sets_checked, m_std_dev, m_mean, m_count, m_overflowed);
                    mismatches++;
                end
                sets_checked++;
            end
        end
    end

    // run limit
    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("[%0t] timeout with %0d of %0d requests taken, %0d results outstanding",
                     $time, requests_taken, total_requests, expected_stats.size());
            $display("population_std_deviation_unit verification failed");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin : run
        int      vals[$];
        int      rand_items;
        int      rand_sets;
        int      full_at;
        int      drop_at;
        int      size;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_sample        = '0;
        s_last          = 1'b0;
        m_ready         = 1'b0;
        req_taken       = 1'b0;
        sample_total    = 0;
        samples_dropped = 1'b0;
        requests_taken  = 0;
        sets_queued     = 0;
        sets_checked    = 0;
        sets_with_drops = 0;
        largest_count   = 0;
        mismatches      = 0;
        cycle_count     = 0;
        burst_left      = 1;
        gap_left        = 0;
        ready_mode      = READY_ALWAYS;
        mode_left       = 0;
        hold_left       = 0;

        // directed sets: single extremes, truncation of a negative mean, constant
        // sets, maximum spread
        vals = '{32767};                          queue_set(vals);
        vals = '{-32768};                         queue_set(vals);
        vals = '{32767, -32768};                  queue_set(vals);
        vals = '{-32768, -32768, -32768};         queue_set(vals);
        vals = '{-3, 0};                          queue_set(vals);
        vals = '{5, 0, 0};                        queue_set(vals);
        vals = '{-32768, 32767, -32768, 32767};   queue_set(vals);
        vals = '{0};                              queue_set(vals);
        vals = '{-1, -1, 1};                      queue_set(vals);

        // random sets; one fills the store exactly, one overruns it and ends
        // on a dropped sample
        full_at    = $urandom_range(5, 25);
        drop_at    = $urandom_range(26, 38);
        rand_items = 0;
        rand_sets  = 0;
        while (rand_items < RAND_ITEMS || rand_sets < RAND_SETS) begin
            if (rand_sets == full_at) begin
                size = PSD_MAX_SAMPLES;
            end else if (rand_sets == drop_at) begin
                size = PSD_MAX_SAMPLES + $urandom_range(1, 6);
            end else if ($urandom_range(0, 7) == 0) begin
                size = $urandom_range(25, 80);
            end else begin
                size = $urandom_range(1, 16);
            end
            queue_random_set(size, spread_t'($urandom_range(0, 3)));
            rand_items += size;
            rand_sets++;
        end
        total_requests = pending_requests.size();

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (requests_taken == total_requests);
        wait (sets_checked == sets_queued);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("covered %0d sets from %0d samples, %0d of them over a full store",
                 sets_checked, total_requests, sets_with_drops);
        $display("largest stored set %0d samples, %0d mismatching results",
                 largest_count, mismatches);
        if (mismatches == 0 && sets_checked == sets_queued) begin
            $display("population_std_deviation_unit verification clean");
        end else begin
            $display("population_std_deviation_unit verification failed");
        end
        $finish;
    end

endmodule
